// ===== src/prrs_pkg.sv =====
// Package: shared types and constants for the priority read request scheduler
`default_nettype none
package prrs_pkg;
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_CHPRI  = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  tag;
        logic [7:0]  pri;
        logic        rd;
        logic [47:0] endp;
    } prrs_cmd_t;
endpackage
`default_nettype wire

// ===== src/prrs_front.sv =====
// Front end: accept transactions, mask the tag and hold them in a short queue
`default_nettype none
module prrs_front
    import prrs_pkg::*;
#(
    parameter int TAG_BITS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  op_tag,
    input  wire logic [7:0]  priority_req,
    input  wire logic        is_read,
    input  wire logic [47:0] end_position,
    output logic             cmd_valid,
    output prrs_cmd_t        cmd,
    input  wire logic        cmd_take
);
    localparam logic [7:0] TagMask = 8'((9'd1 << TAG_BITS) - 9'd1);

    prrs_cmd_t  q_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;
    logic       push, pop;

    assign in_stall  = (cnt_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign pop       = cmd_take && (cnt_reg != 2'd0);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    // Advance queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // Store the incoming transaction
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg].mode <= mode;
            q_reg[wp_reg].tag  <= op_tag & TagMask;
            q_reg[wp_reg].pri  <= priority_req;
            q_reg[wp_reg].rd   <= is_read;
            q_reg[wp_reg].endp <= end_position;
        end
    end
endmodule
`default_nettype wire

// ===== src/prrs_back.sv =====
// Back end: sorted register array with parallel compare, insert, pop and reprioritize
`default_nettype none
module prrs_back
    import prrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       sort_by_position,
    input  wire logic       cmd_valid,
    input  wire prrs_cmd_t  cmd,
    output logic            cmd_take,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            served_valid,
    output logic [7:0]      served_tag,
    output logic            accepted,
    output logic [4:0]      queue_count
);
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_REMOVE, S_INSERT, S_POPSCAN, S_DONE} state_t;

    logic [7:0]        tag_reg  [QUEUE_DEPTH];
    logic signed [7:0] pri_reg  [QUEUE_DEPTH];
    logic              rd_reg   [QUEUE_DEPTH];
    logic [47:0]       end_reg  [QUEUE_DEPTH];

    state_t      state_reg;
    logic [CW-1:0] count_reg;
    logic [47:0] budget_reg;
    prrs_cmd_t   cur_reg;
    logic        sv_reg, acc_reg;
    logic [7:0]  stag_reg;

    // Per-slot compare results
    logic [QUEUE_DEPTH-1:0] live, ins_hit, tag_hit, scan_ok, scan_hit;
    logic [IW-1:0] ins_pos, rm_pos, sub_pos;
    logic          ins_any, rm_any, sub_any;
    logic          run_ok;

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            live[i]    = (CW'(i) < count_reg);
            ins_hit[i] = live[i] && (($signed(cur_reg.pri) > pri_reg[i]) ||
                         (($signed(cur_reg.pri) == pri_reg[i]) && sort_by_position &&
                          cur_reg.rd && rd_reg[i] && (cur_reg.endp < end_reg[i])));
            tag_hit[i] = live[i] && (tag_reg[i] == cur_reg.tag);
            scan_ok[i] = live[i] && rd_reg[i] && (pri_reg[i] == $signed(cur_reg.pri));
        end
        // leading run: slot must be preceded only by scan_ok slots
        run_ok = 1'b1;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            scan_hit[i] = run_ok && scan_ok[i] && (budget_reg < end_reg[i]);
            run_ok      = run_ok && scan_ok[i];
        end
        ins_any = 1'b0; ins_pos = IW'(count_reg);
        rm_any  = 1'b0; rm_pos  = '0;
        sub_any = 1'b0; sub_pos = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (ins_hit[i])  begin ins_any = 1'b1; ins_pos = IW'(i); end
            if (tag_hit[i])  begin rm_any  = 1'b1; rm_pos  = IW'(i); end
            if (scan_hit[i]) begin sub_any = 1'b1; sub_pos = IW'(i); end
        end
        if (!ins_any) ins_pos = IW'(count_reg);
    end

    assign cmd_take     = (state_reg == S_IDLE);
    assign out_valid    = (state_reg == S_DONE);
    assign served_valid = sv_reg;
    assign served_tag   = stag_reg;
    assign accepted     = acc_reg;
    assign queue_count  = 5'(count_reg);

    // Sequence one transaction at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            budget_reg <= '0;
            sv_reg     <= 1'b0;
            acc_reg    <= 1'b0;
            stag_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        case (cmd.mode)
                            MODE_INSERT:
                            begin
                                sv_reg   <= 1'b0;
                                stag_reg <= '0;
                                if (count_reg < CW'(QUEUE_DEPTH))
                                begin
                                    acc_reg   <= 1'b1;
                                    state_reg <= S_INSERT;
                                end
                                else
                                begin
                                    acc_reg   <= 1'b0;
                                    state_reg <= S_DONE;
                                end
                            end
                            MODE_POP:
                            begin
                                acc_reg <= 1'b0;
                                if (count_reg != '0)
                                begin
                                    sv_reg    <= 1'b1;
                                    stag_reg  <= tag_reg[0];
                                    state_reg <= S_POPSCAN;
                                end
                                else
                                begin
                                    sv_reg    <= 1'b0;
                                    stag_reg  <= '0;
                                    state_reg <= S_DONE;
                                end
                            end
                            MODE_CHPRI:
                            begin
                                sv_reg    <= 1'b0;
                                acc_reg   <= 1'b0;
                                stag_reg  <= '0;
                                state_reg <= S_REMOVE;
                            end
                            default:
                            begin
                                sv_reg    <= 1'b0;
                                acc_reg   <= 1'b0;
                                stag_reg  <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_REMOVE:
                begin
                    if (rm_any)
                    begin
                        acc_reg   <= 1'b1;
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_INSERT;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_INSERT:
                begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_DONE;
                end
                S_POPSCAN:
                begin
                    // head still in slot 0; cur_reg holds head, scan slots 1..
                    if (cur_reg.rd && sort_by_position)
                    begin
                        if (budget_reg != '0 && cur_reg.endp < budget_reg && sub_any)
                        begin
                            stag_reg   <= tag_reg[sub_pos];
                            budget_reg <= end_reg[sub_pos];
                        end
                        else
                            budget_reg <= cur_reg.endp;
                    end
                    count_reg <= count_reg - CW'(1);
                    state_reg <= S_DONE;
                end
                S_DONE:
                    if (!out_stall) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Current operand: command, or head / removed entry fields
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
        begin
            if (cmd.mode == MODE_POP)
            begin
                cur_reg.mode <= cmd.mode;
                cur_reg.tag  <= tag_reg[0];
                cur_reg.pri  <= pri_reg[0];
                cur_reg.rd   <= rd_reg[0];
                cur_reg.endp <= end_reg[0];
            end
            else
                cur_reg <= cmd;
        end
        else if (state_reg == S_REMOVE && rm_any)
        begin
            cur_reg.rd   <= rd_reg[rm_pos];
            cur_reg.endp <= end_reg[rm_pos];
        end
    end

    // Shift the entry array
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (state_reg == S_INSERT)
            begin
                if (IW'(i) == ins_pos)
                begin
                    tag_reg[i] <= cur_reg.tag;
                    pri_reg[i] <= cur_reg.pri;
                    rd_reg[i]  <= cur_reg.rd;
                    end_reg[i] <= cur_reg.endp;
                end
                else if (i > 0 && IW'(i) > ins_pos)
                begin
                    tag_reg[i] <= tag_reg[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                    pri_reg[i] <= pri_reg[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                    rd_reg[i]  <= rd_reg[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                    end_reg[i] <= end_reg[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                end
            end
            else if ((state_reg == S_REMOVE && rm_any && IW'(i) >= rm_pos) ||
                     (state_reg == S_POPSCAN &&
                      !(cur_reg.rd && sort_by_position && budget_reg != '0 &&
                        cur_reg.endp < budget_reg && sub_any && IW'(i) < sub_pos)))
            begin
                if (i + 1 < QUEUE_DEPTH)
                begin
                    tag_reg[i] <= tag_reg[(i + 1) % QUEUE_DEPTH];
                    pri_reg[i] <= pri_reg[(i + 1) % QUEUE_DEPTH];
                    rd_reg[i]  <= rd_reg[(i + 1) % QUEUE_DEPTH];
                    end_reg[i] <= end_reg[(i + 1) % QUEUE_DEPTH];
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/priority_read_request_scheduler.sv =====
// Top level: priority read request scheduler
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  input    | in_valid/in_stall  | mode, op_tag, priority_req, is_read, end_pos
//  output   | out_valid/out_stall| served_valid, served_tag, accepted, count
//  config   | cfg_we             | cfg_wdata (sort_by_position)
//
// In the back end a transaction is issued from idle; a refused insert, an empty
// pop or an unused mode goes straight to the result state, an insert or pop has
// its own state and a priority change removes then inserts (if the tag is found).
// A two-entry queue keeps accepting while the back end works.
// Reset empties the queue and clears the budget and sort flag.
// A stalled result holds the back end; the front queue fills then stalls.
`default_nettype none
module priority_read_request_scheduler
    import prrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  op_tag,
    input  wire logic [7:0]  priority_req,
    input  wire logic        is_read,
    input  wire logic [47:0] end_position,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             served_valid,
    output logic [7:0]       served_tag,
    output logic             accepted,
    output logic [4:0]       queue_count
);
    logic      sort_reg;
    logic      cmd_valid, cmd_take;
    prrs_cmd_t cmd;

    // Hold the sort flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sort_reg <= 1'b0;
        else if (cfg_we)
            sort_reg <= cfg_wdata;
    end

    prrs_front #(.TAG_BITS(TAG_BITS)) u_front (
        .clk, .rst_n, .in_valid, .in_stall, .mode, .op_tag, .priority_req,
        .is_read, .end_position, .cmd_valid, .cmd, .cmd_take
    );

    prrs_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .clk, .rst_n, .sort_by_position(sort_reg), .cmd_valid, .cmd, .cmd_take,
        .out_valid, .out_stall, .served_valid, .served_tag, .accepted, .queue_count
    );
endmodule
`default_nettype wire

// ===== sim/priority_read_request_scheduler_tb.sv =====
// Testbench for the priority read request scheduler: directed and random transactions
`default_nettype none
module priority_read_request_scheduler_tb;
    import prrs_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic       served_valid;
        logic [7:0] served_tag;
        logic       accepted;
        logic [4:0] queue_count;
    } sched_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [7:0]  op_tag;
    logic [7:0]  priority_req;
    logic        is_read;
    logic [47:0] end_position;
    logic        out_valid;
    logic        out_stall;
    logic        served_valid;
    logic [7:0]  served_tag;
    logic        accepted;
    logic [4:0]  queue_count;

    priority_read_request_scheduler i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .op_tag       (op_tag),
        .priority_req (priority_req),
        .is_read      (is_read),
        .end_position (end_position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .served_valid (served_valid),
        .served_tag   (served_tag),
        .accepted     (accepted),
        .queue_count  (queue_count)
    );

    // Shadow queue state
    logic [7:0]        q_tag [DEPTH];
    logic signed [7:0] q_pri [DEPTH];
    logic              q_rd  [DEPTH];
    logic [47:0]       q_end [DEPTH];
    int                q_count;
    logic [47:0]       budget;
    logic              sort_on;

    sched_result_t expected_results[$];
    int  mismatches;
    int  send_idle_pct;
    int  recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("** priority_read_request_scheduler: FAILED **");
        $finish;
    end

    task automatic q_remove(input int pos);
        for (int i = pos; i + 1 < q_count; i++)
        begin
            q_tag[i] = q_tag[i+1];
            q_pri[i] = q_pri[i+1];
            q_rd[i]  = q_rd[i+1];
            q_end[i] = q_end[i+1];
        end
        q_count--;
    endtask

    task automatic q_put_at(input int pos, input logic [7:0] t, input logic signed [7:0] p,
                            input logic r, input logic [47:0] e);
        for (int i = q_count; i > pos; i--)
        begin
            q_tag[i] = q_tag[i-1];
            q_pri[i] = q_pri[i-1];
            q_rd[i]  = q_rd[i-1];
            q_end[i] = q_end[i-1];
        end
        q_tag[pos] = t;
        q_pri[pos] = p;
        q_rd[pos]  = r;
        q_end[pos] = e;
        q_count++;
    endtask

    task automatic q_place(input logic [7:0] t, input logic signed [7:0] p,
                           input logic r, input logic [47:0] e);
        int pos;
        for (pos = 0; pos < q_count; pos++)
        begin
            if (p > q_pri[pos])
                break;
            if (p == q_pri[pos] && sort_on && r && q_rd[pos] && e < q_end[pos])
                break;
        end
        q_put_at(pos, t, p, r, e);
    endtask

    // Advance the shadow queue by one transaction and return its result
    task automatic schedule_step(input prrs_cmd_t c, output sched_result_t res);
        logic [7:0]        htag;
        logic signed [7:0] hpri;
        logic              hrd;
        logic [47:0]       hend;
        logic [47:0]       newend;
        res = '0;
        if (c.mode == MODE_INSERT)
        begin
            if (q_count < DEPTH)
            begin
                q_place(c.tag, c.pri, c.rd, c.endp);
                res.accepted = 1'b1;
            end
        end
        else if (c.mode == MODE_POP)
        begin
            if (q_count > 0)
            begin
                htag = q_tag[0];
                hpri = q_pri[0];
                hrd  = q_rd[0];
                hend = q_end[0];
                q_remove(0);
                res.served_valid = 1'b1;
                res.served_tag   = htag;
                if (hrd && sort_on)
                begin
                    newend = hend;
                    if (budget != 0 && hend < budget)
                    begin
                        for (int i = 0; i < q_count; i++)
                        begin
                            if (!q_rd[i] || q_pri[i] != hpri)
                                break;
                            if (budget < q_end[i])
                            begin
                                res.served_tag = q_tag[i];
                                newend = q_end[i];
                                q_remove(i);
                                q_put_at(0, htag, hpri, hrd, hend);
                                break;
                            end
                        end
                    end
                    budget = newend;
                end
            end
        end
        else if (c.mode == MODE_CHPRI)
        begin
            for (int i = 0; i < q_count; i++)
            begin
                if (q_tag[i] == c.tag)
                begin
                    hrd  = q_rd[i];
                    hend = q_end[i];
                    q_remove(i);
                    q_place(c.tag, c.pri, hrd, hend);
                    res.accepted = 1'b1;
                    break;
                end
            end
        end
        res.queue_count = 5'(q_count);
    endtask

    // Send one transaction and queue its expected result
    task automatic send_cmd(input prrs_cmd_t c);
        sched_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= c.mode;
        op_tag       <= c.tag;
        priority_req <= c.pri;
        is_read      <= c.rd;
        end_position <= c.endp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        schedule_step(c, res);
        expected_results.push_back(res);
    endtask

    task automatic send_fields(input logic [1:0] m, input logic [7:0] t, input logic [7:0] p,
                               input logic r, input logic [47:0] e);
        prrs_cmd_t c;
        c.mode = m;
        c.tag  = t;
        c.pri  = p;
        c.rd   = r;
        c.endp = e;
        send_cmd(c);
    endtask

    // Hold until every expected result is back, then let the back end settle
    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_results.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_sort(input logic v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sort_on = v;
        @(posedge clk);
    endtask

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        sched_result_t got;
        sched_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {served_valid, served_tag, accepted, queue_count};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp valid=%b tag=%0d acc=%b cnt=%0d, ",
                                  "got valid=%b tag=%0d acc=%b cnt=%0d"},
                                 exp_r.served_valid, exp_r.served_tag, exp_r.accepted,
                                 exp_r.queue_count, got.served_valid, got.served_tag,
                                 got.accepted, got.queue_count);
                end
            end
        end
    end

    // Drive receiver stall at random
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Fill past full, then drain past empty; covers field extremes
    task automatic test_full_and_empty();
        send_fields(MODE_POP, 8'd0, 8'd0, 1'b0, 48'd0);
        for (int i = 0; i < DEPTH + 1; i++)
            send_fields(MODE_INSERT, 8'(i == 0 ? 255 : i), (i % 2) ? 8'h80 : 8'h7f,
                        1'(i), (i % 2) ? 48'hFFFF_FFFF_FFFF : 48'd0);
        send_fields(MODE_UNUSED, 8'hff, 8'hff, 1'b1, 48'hFFFF_FFFF_FFFF);
        for (int i = 0; i < DEPTH + 1; i++)
            send_fields(MODE_POP, 8'd0, 8'd0, 1'b0, 48'd0);
    endtask

    // Reprioritize, duplicate tags, missing tag
    task automatic test_change_priority();
        send_fields(MODE_INSERT, 8'd5, 8'd1, 1'b1, 48'd100);
        send_fields(MODE_INSERT, 8'd5, 8'd2, 1'b0, 48'd50);
        send_fields(MODE_INSERT, 8'd7, 8'd1, 1'b1, 48'd10);
        send_fields(MODE_CHPRI, 8'd5, 8'd3, 1'b0, 48'd0);
        send_fields(MODE_CHPRI, 8'd9, 8'd3, 1'b0, 48'd0);
        send_fields(MODE_CHPRI, 8'd7, 8'h80, 1'b0, 48'd0);
        repeat (4) send_fields(MODE_POP, 8'd0, 8'd0, 1'b0, 48'd0);
    endtask

    // Read ordering by end and budget substitution at pop
    task automatic test_read_substitution();
        send_fields(MODE_INSERT, 8'd1, 8'd4, 1'b1, 48'd500);
        send_fields(MODE_POP, 8'd0, 8'd0, 1'b0, 48'd0);
        send_fields(MODE_INSERT, 8'd2, 8'd4, 1'b1, 48'd600);
        send_fields(MODE_INSERT, 8'd3, 8'd4, 1'b1, 48'd100);
        send_fields(MODE_INSERT, 8'd4, 8'd4, 1'b1, 48'd300);
        repeat (4) send_fields(MODE_POP, 8'd0, 8'd0, 1'b0, 48'd0);
    endtask

    // Random stream biased toward small tag, priority and end ranges
    task automatic test_random(input int n);
        prrs_cmd_t c;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            c.mode = (r < 45) ? MODE_INSERT : (r < 80) ? MODE_POP :
                     (r < 98) ? MODE_CHPRI : MODE_UNUSED;
            c.tag = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
            c.pri = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
            c.rd  = ($urandom_range(3) != 0);
            if ($urandom_range(7) == 0)
                c.endp = {16'($urandom), 32'($urandom)};
            else
                c.endp = 48'($urandom_range(64));
            send_cmd(c);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_INSERT;
        op_tag       = '0;
        priority_req = '0;
        is_read      = 1'b0;
        end_position = '0;
        q_count      = 0;
        budget       = '0;
        sort_on      = 1'b0;
        mismatches   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_sort(1'b0);
        test_full_and_empty();
        test_change_priority();
        write_sort(1'b1);
        test_full_and_empty();
        test_change_priority();
        test_read_substitution();

        send_idle_pct = 47;
        test_random(300);
        write_sort(1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 47;
        test_random(300);
        write_sort(1'b1);
        send_idle_pct = 26;
        recv_stall_pct = 26;
        test_random(300);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(300);

        drain();
        recv_stall_pct = 0;
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("** priority_read_request_scheduler: PASSED **");
        else
            $display("** priority_read_request_scheduler: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/prrs_pkg.sv
src/prrs_front.sv
src/prrs_back.sv
src/priority_read_request_scheduler.sv
sim/priority_read_request_scheduler_tb.sv
